// ===== hw/rtl/thpq_pkg.sv =====
`default_nettype none
package thpq_pkg;

  localparam int unsigned DEF_CAPACITY = 1024;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POP    = 1'b1;

  // datapath micro-operations
  localparam logic [3:0] OP_NONE       = 4'd0;
  localparam logic [3:0] OP_INS_ACC    = 4'd1;
  localparam logic [3:0] OP_FULL       = 4'd2;
  localparam logic [3:0] OP_EMPTY      = 4'd3;
  localparam logic [3:0] OP_POP_ACC    = 4'd4;
  localparam logic [3:0] OP_TOP        = 4'd5;
  localparam logic [3:0] OP_UP_CALC    = 4'd6;
  localparam logic [3:0] OP_UP_RD      = 4'd7;
  localparam logic [3:0] OP_CLIMB_MOVE = 4'd8;
  localparam logic [3:0] OP_CLIMB_PUT  = 4'd9;
  localparam logic [3:0] OP_SD_RD      = 4'd10;
  localparam logic [3:0] OP_SD_STEP    = 4'd11;
  localparam logic [3:0] OP_FILL_RD    = 4'd12;
  localparam logic [3:0] OP_FILL       = 4'd13;
  localparam logic [3:0] OP_OUT        = 4'd14;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] idx;
  } entry_t;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic n_is1;
    logic pos_gt1;
    logic climb_go;
    logic c_le_n;
    logic hole_lt_n;
    logic more;
    logic out_busy;
  } stat_t;

  // true when key a must stand above key b; zero ranks last
  function automatic logic ranks_before(input logic [31:0] a, input logic [31:0] b);
    logic r;
    if (a == 32'd0) begin
      r = 1'b0;
    end else if (b == 32'd0) begin
      r = 1'b1;
    end else begin
      r = (a < b);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/thpq_dp.sv =====
`default_nettype none
module thpq_dp #(
  parameter int unsigned CAPACITY = thpq_pkg::DEF_CAPACITY
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  thpq_pkg::cmd_t       cmd,
  output thpq_pkg::stat_t      stat,
  input  wire  [31:0]          in_item_index,
  input  wire  [31:0]          in_item_key,
  input  wire                  out_ready,
  output logic                 out_valid,
  output logic [31:0]          out_result_index,
  output logic [31:0]          out_result_key,
  output logic [1:0]           out_status,
  output logic [10:0]          out_entry_count
);

  localparam int unsigned AW  = $clog2(CAPACITY);
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned PW  = $clog2(3 * CAPACITY + 2);
  localparam int unsigned KS  = PW + 2;
  localparam int unsigned MUL = ((1 << KS) + 2) / 3;

  thpq_pkg::entry_t mem [CAPACITY];
  thpq_pkg::entry_t rdata_r;
  logic [AW-1:0]    raddr;
  logic             we;
  logic [AW-1:0]    waddr;
  thpq_pkg::entry_t wdata;

  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    n_r, n_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic [PW-1:0]    up_r, up_nxt;
  logic [PW-1:0]    hole_r, hole_nxt;
  logic [PW-1:0]    c_r, c_nxt;
  logic [PW-1:0]    j_r, j_nxt;
  logic [PW-1:0]    best_r, best_nxt;
  thpq_pkg::entry_t best_e_r, best_e_nxt;
  thpq_pkg::entry_t e_r, e_nxt;
  logic             first_r, first_nxt;
  thpq_pkg::entry_t res_r, res_nxt;
  logic [1:0]       st_r, st_nxt;
  logic             out_valid_r, out_valid_nxt;
  thpq_pkg::entry_t out_e_r, out_e_nxt;
  logic [1:0]       out_st_r, out_st_nxt;
  logic [CW-1:0]    out_cnt_r, out_cnt_nxt;

  logic [PW-1:0]    n_ext;
  logic [PW-1:0]    c_calc;
  logic [PW-1:0]    j1;
  logic [PW-1:0]    pm2;
  logic [PW+KS-1:0] prod;
  logic             take;
  logic [PW-1:0]    sel_pos;
  thpq_pkg::entry_t sel_e;
  logic [CW+10:0]   cnt_ext;

  assign n_ext  = PW'(n_r);
  assign c_calc = {hole_r[PW-2:0], 1'b0} + hole_r - PW'(1);
  assign j1     = j_r + PW'(1);
  assign pm2    = pos_r - PW'(2);
  assign prod   = (PW+KS)'(pm2) * (PW+KS)'(MUL);
  assign take   = first_r || thpq_pkg::ranks_before(rdata_r.key, best_e_r.key);
  assign sel_pos = take ? j_r : best_r;
  assign sel_e   = take ? rdata_r : best_e_r;

  always_comb begin
    stat.full      = (count_r == CW'(CAPACITY));
    stat.empty     = (count_r == '0);
    stat.n_is1     = (n_r == CW'(1));
    stat.pos_gt1   = (pos_r > PW'(1));
    stat.climb_go  = thpq_pkg::ranks_before(e_r.key, rdata_r.key);
    stat.c_le_n    = (c_calc <= n_ext);
    stat.hole_lt_n = (hole_r < n_ext);
    stat.more      = (j1 <= n_ext) && (j1 < c_r + PW'(3));
    stat.out_busy  = out_valid_r;
  end

  always_comb begin
    count_nxt     = count_r;
    n_nxt         = n_r;
    pos_nxt       = pos_r;
    up_nxt        = up_r;
    hole_nxt      = hole_r;
    c_nxt         = c_r;
    j_nxt         = j_r;
    best_nxt      = best_r;
    best_e_nxt    = best_e_r;
    e_nxt         = e_r;
    first_nxt     = first_r;
    res_nxt       = res_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_e_nxt     = out_e_r;
    out_st_nxt    = out_st_r;
    out_cnt_nxt   = out_cnt_r;
    raddr         = '0;
    we            = 1'b0;
    waddr         = '0;
    wdata         = e_r;
    unique case (cmd.op)
      thpq_pkg::OP_NONE: begin
      end
      thpq_pkg::OP_INS_ACC: begin
        count_nxt = count_r + CW'(1);
        pos_nxt   = PW'(count_r) + PW'(1);
        e_nxt     = '{key: in_item_key, idx: in_item_index};
        res_nxt   = '0;
        st_nxt    = thpq_pkg::ST_OK;
      end
      thpq_pkg::OP_FULL: begin
        res_nxt = '0;
        st_nxt  = thpq_pkg::ST_FULL;
      end
      thpq_pkg::OP_EMPTY: begin
        res_nxt = '0;
        st_nxt  = thpq_pkg::ST_EMPTY;
      end
      thpq_pkg::OP_POP_ACC: begin
        n_nxt     = count_r;
        count_nxt = count_r - CW'(1);
        st_nxt    = thpq_pkg::ST_OK;
        raddr     = '0;
      end
      thpq_pkg::OP_TOP: begin
        res_nxt  = rdata_r;
        hole_nxt = PW'(1);
      end
      thpq_pkg::OP_UP_CALC: begin
        up_nxt = PW'(prod >> KS) + PW'(1);
      end
      thpq_pkg::OP_UP_RD: begin
        raddr = AW'(up_r - PW'(1));
      end
      thpq_pkg::OP_CLIMB_MOVE: begin
        we      = 1'b1;
        waddr   = AW'(pos_r - PW'(1));
        wdata   = rdata_r;
        pos_nxt = up_r;
      end
      thpq_pkg::OP_CLIMB_PUT: begin
        we    = 1'b1;
        waddr = AW'(pos_r - PW'(1));
        wdata = e_r;
      end
      thpq_pkg::OP_SD_RD: begin
        raddr     = AW'(c_calc - PW'(1));
        c_nxt     = c_calc;
        j_nxt     = c_calc;
        first_nxt = 1'b1;
      end
      thpq_pkg::OP_SD_STEP: begin
        first_nxt  = 1'b0;
        best_nxt   = sel_pos;
        best_e_nxt = sel_e;
        if (stat.more) begin
          raddr = AW'(j_r);
          j_nxt = j1;
        end else begin
          we       = 1'b1;
          waddr    = AW'(hole_r - PW'(1));
          wdata    = sel_e;
          hole_nxt = sel_pos;
        end
      end
      thpq_pkg::OP_FILL_RD: begin
        raddr = AW'(n_ext - PW'(1));
      end
      thpq_pkg::OP_FILL: begin
        e_nxt   = rdata_r;
        pos_nxt = hole_r;
      end
      thpq_pkg::OP_OUT: begin
        out_valid_nxt = 1'b1;
        out_e_nxt     = res_r;
        out_st_nxt    = st_r;
        out_cnt_nxt   = count_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      first_r     <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      first_r     <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    pos_r    <= pos_nxt;
    up_r     <= up_nxt;
    hole_r   <= hole_nxt;
    c_r      <= c_nxt;
    j_r      <= j_nxt;
    best_r   <= best_nxt;
    best_e_r <= best_e_nxt;
    e_r      <= e_nxt;
    res_r    <= res_nxt;
    st_r     <= st_nxt;
    out_e_r  <= out_e_nxt;
    out_st_r <= out_st_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  assign cnt_ext          = (CW+11)'(out_cnt_r);
  assign out_valid        = out_valid_r;
  assign out_result_index = out_e_r.idx;
  assign out_result_key   = out_e_r.key;
  assign out_status       = out_st_r;
  assign out_entry_count  = cnt_ext[10:0];

endmodule
`default_nettype wire

// ===== hw/rtl/thpq_ctrl.sv =====
`default_nettype none
module thpq_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  input  wire              in_req_type,
  output logic             in_ready,
  input  thpq_pkg::stat_t  stat,
  output thpq_pkg::cmd_t   cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TOP   = 4'd1;
  localparam logic [3:0] S_UPC   = 4'd2;
  localparam logic [3:0] S_UPR   = 4'd3;
  localparam logic [3:0] S_UPW   = 4'd4;
  localparam logic [3:0] S_SDC   = 4'd5;
  localparam logic [3:0] S_SDD   = 4'd6;
  localparam logic [3:0] S_FILLW = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = thpq_pkg::OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_req_type == thpq_pkg::REQ_INSERT) begin
            if (stat.full) begin
              cmd.op    = thpq_pkg::OP_FULL;
              state_nxt = S_FIN;
            end else begin
              cmd.op    = thpq_pkg::OP_INS_ACC;
              state_nxt = S_UPC;
            end
          end else if (stat.empty) begin
            cmd.op    = thpq_pkg::OP_EMPTY;
            state_nxt = S_FIN;
          end else begin
            cmd.op    = thpq_pkg::OP_POP_ACC;
            state_nxt = S_TOP;
          end
        end
      end
      S_TOP: begin
        cmd.op    = thpq_pkg::OP_TOP;
        state_nxt = stat.n_is1 ? S_FIN : S_SDC;
      end
      S_UPC: begin
        if (stat.pos_gt1) begin
          cmd.op    = thpq_pkg::OP_UP_CALC;
          state_nxt = S_UPR;
        end else begin
          cmd.op    = thpq_pkg::OP_CLIMB_PUT;
          state_nxt = S_FIN;
        end
      end
      S_UPR: begin
        cmd.op    = thpq_pkg::OP_UP_RD;
        state_nxt = S_UPW;
      end
      S_UPW: begin
        if (stat.climb_go) begin
          cmd.op    = thpq_pkg::OP_CLIMB_MOVE;
          state_nxt = S_UPC;
        end else begin
          cmd.op    = thpq_pkg::OP_CLIMB_PUT;
          state_nxt = S_FIN;
        end
      end
      S_SDC: begin
        if (stat.c_le_n) begin
          cmd.op    = thpq_pkg::OP_SD_RD;
          state_nxt = S_SDD;
        end else if (stat.hole_lt_n) begin
          cmd.op    = thpq_pkg::OP_FILL_RD;
          state_nxt = S_FILLW;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SDD: begin
        cmd.op    = thpq_pkg::OP_SD_STEP;
        state_nxt = stat.more ? S_SDD : S_SDC;
      end
      S_FILLW: begin
        cmd.op    = thpq_pkg::OP_FILL;
        state_nxt = S_UPC;
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.op    = thpq_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ternary_heap_priority_queue_top.sv =====
`default_nettype none
// Ternary min-heap priority queue of (index, key) words. An insert word
// appends the entry and sifts it up; a pop word returns the root and refills
// the heap. A smaller nonzero key ranks first, key zero ranks last, and equal
// keys need not keep their order. One request is in work at a time; each
// produces one result word, which waits in an output register while the next
// request is taken. Timing is set by the single-port-read heap memory. An
// insert climbs one level per parent address, read and compare, and stops at
// the root or at a parent that the entry does not rank before. A pop walks
// the hole down to the bottom, reading the children of the hole in turn and
// moving the best one up, then refills the hole with the last entry and lets
// it climb. A result word that is not taken holds the next request in its
// final state. Inserting into a full queue drops the entry and reports
// status 2; popping an empty queue reports status 1. No clearing pass is
// needed after reset.
module ternary_heap_priority_queue_top #(
  parameter int unsigned CAPACITY = thpq_pkg::DEF_CAPACITY
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         in_req_type,
  input  wire  [31:0] in_item_index,
  input  wire  [31:0] in_item_key,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] out_result_index,
  output logic [31:0] out_result_key,
  output logic [1:0]  out_status,
  output logic [10:0] out_entry_count
);

  thpq_pkg::cmd_t  cmd;
  thpq_pkg::stat_t stat;

  // sequence the insert and pop walks
  thpq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_req_type(in_req_type),
    .in_ready   (in_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // hold heap memory, count, walk registers and the result word
  thpq_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_item_index   (in_item_index),
    .in_item_key     (in_item_key),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_result_index(out_result_index),
    .out_result_key  (out_result_key),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

endmodule
`default_nettype wire
